// ----- design/circular_deque_assert.svh -----
// Assertion macros shared by the deque checker.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Same-cycle implication
`define CDQ_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed");

// Next-cycle implication
`define CDQ_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

// ----- design/cdq_pkg.sv -----
package cdq_pkg;

   // Store geometry
   localparam int DEPTH      = 128;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int CAP_W      = 8;
   localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [CAP_W-1:0]      cap_type;
   typedef logic [DATA_WIDTH-1:0] data_type;

   // Operation codes
   typedef enum logic [1:0] {
      FUNC_PUSH_FRONT = 2'd0,
      FUNC_PUSH_REAR  = 2'd1,
      FUNC_POP_FRONT  = 2'd2,
      FUNC_POP_REAR   = 2'd3
   } func_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;  // take the request beat, update pointers, access store
      logic load;    // move the pending result into the response register
      logic cfg_wr;  // capacity write, empties the deque
   } cmd_type;

endpackage

// ----- design/cdq_ctrl.sv -----
module cdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic             csr_valid,
   output logic             csr_ready,
   output cdq_pkg::cmd_type cmd
);
   import cdq_pkg::*;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Accept only when idle and the response slot is free by the next edge;
   // a pending capacity write goes first and holds off the request beat
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall) || csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign cmd.accept = req_valid && !req_stall;
   assign cmd.load   = (state_ff == ST_LOAD);
   assign cmd.cfg_wr = csr_valid && csr_ready;
   assign rsp_valid  = rsp_valid_ff;

   // Next state and response valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/cdq_dp.sv -----
module cdq_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cdq_pkg::cmd_type                     cmd,
   input  logic [1:0]                           req_func,
   input  logic signed [cdq_pkg::DATA_WIDTH-1:0] req_value,
   input  logic [cdq_pkg::CAP_W-1:0]            csr_capacity,
   output logic signed [cdq_pkg::DATA_WIDTH-1:0] rsp_removed_value,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_is_full
);
   import cdq_pkg::*;

   function automatic addr_type inc_wrap(addr_type idx, cnt_type cap);
      cnt_type sum;
      sum = {1'b0, idx} + cnt_type'(1);
      return (sum >= cap) ? '0 : sum[ADDR_W-1:0];
   endfunction

   function automatic addr_type dec_wrap(addr_type idx, cnt_type cap);
      cnt_type top;
      top = cap - cnt_type'(1);
      return (idx == '0) ? top[ADDR_W-1:0] : idx - addr_type'(1);
   endfunction

   // Store
   data_type store_mem [DEPTH];
   data_type rd_data_ff;

   // Pointer state
   cap_type  cap_ff, cap_in;
   addr_type head_ff, head_in;
   addr_type tail_ff, tail_in;
   logic     empty_ff, empty_in;

   // Pending result of the accepted beat
   status_type pend_status_ff, pend_status_in;
   logic       pend_pop_ok_ff, pend_pop_ok_in;
   logic       pend_empty_ff;
   logic       pend_full_ff, pend_full_in;

   // Response register
   data_type   rsp_value_ff;
   status_type rsp_status_ff;
   logic       rsp_empty_ff;
   logic       rsp_full_ff;

   cnt_type  cap_eff;
   addr_type head_c, tail_c;
   logic     full_now;
   logic     wr_en;
   addr_type wr_addr;
   addr_type rd_addr;
   func_type func;

   assign func = func_type'(req_func);

   // Effective capacity: zero reads as one, saturates at the store depth
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = cnt_type'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(DEPTH)) begin
         cap_eff = cnt_type'(DEPTH);
      end else begin
         cap_eff = cnt_type'(CMP_W'(cap_ff));
      end
   end

   assign head_c   = (cnt_type'(head_ff) >= cap_eff) ? '0 : head_ff;
   assign tail_c   = (cnt_type'(tail_ff) >= cap_eff) ? '0 : tail_ff;
   assign full_now = !empty_ff && (inc_wrap(tail_c, cap_eff) == head_c);

   // Operation decode and pointer update
   always_comb begin
      head_in        = head_c;
      tail_in        = tail_c;
      empty_in       = empty_ff;
      pend_status_in = STATUS_DONE;
      pend_pop_ok_in = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = '0;
      rd_addr        = (func == FUNC_POP_FRONT) ? head_c : tail_c;
      case (func)
         FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
            if (full_now) begin
               pend_status_in = STATUS_OVERFLOW;
            end else if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               wr_en    = 1'b1;
               wr_addr  = '0;
            end else if (func == FUNC_PUSH_FRONT) begin
               head_in = dec_wrap(head_c, cap_eff);
               wr_en   = 1'b1;
               wr_addr = head_in;
            end else begin
               tail_in = inc_wrap(tail_c, cap_eff);
               wr_en   = 1'b1;
               wr_addr = tail_in;
            end
         end
         default: begin
            if (empty_ff) begin
               pend_status_in = STATUS_UNDERFLOW;
            end else begin
               pend_pop_ok_in = 1'b1;
               if (head_c == tail_c) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else if (func == FUNC_POP_FRONT) begin
                  head_in = inc_wrap(head_c, cap_eff);
               end else begin
                  tail_in = dec_wrap(tail_c, cap_eff);
               end
            end
         end
      endcase
      pend_full_in = !empty_in && (inc_wrap(tail_in, cap_eff) == head_in);
      cap_in       = cap_ff;
      if (cmd.cfg_wr) begin
         cap_in = csr_capacity;
      end
   end

   // Pointer and capacity registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (cmd.cfg_wr) begin
         cap_ff   <= cap_in;
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (cmd.accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   // Store: one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         store_mem[wr_addr] <= data_type'(req_value);
      end
      if (cmd.accept) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Pending result and response payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_status_ff <= pend_status_in;
         pend_pop_ok_ff <= pend_pop_ok_in;
         pend_empty_ff  <= empty_in;
         pend_full_ff   <= pend_full_in;
      end
      if (cmd.load) begin
         rsp_value_ff  <= pend_pop_ok_ff ? rd_data_ff : '0;
         rsp_status_ff <= pend_status_ff;
         rsp_empty_ff  <= pend_empty_ff;
         rsp_full_ff   <= pend_full_ff;
      end
   end

   assign rsp_removed_value = $signed(rsp_value_ff);
   assign rsp_status        = rsp_status_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_is_full       = rsp_full_ff;

endmodule

// ----- design/circular_deque.sv -----
// Double-ended queue in a circular store of up to 128 words.
// Request channel (req_valid / req_stall): one beat carries req_func
// (push front, push rear, pop front, pop rear) and req_value.
// Response channel (rsp_valid / rsp_stall): one beat per request with the
// popped word (zero otherwise), a status (done, overflow, underflow) and
// the empty and full flags after the operation.
// Capacity port (csr_valid / csr_ready): writes the wrap point; zero acts
// as one and values above the depth saturate. A write empties the deque,
// and while one is offered the request side is stalled.
// rsp_valid rises once the controller has passed through its load state
// after the request beat, together with the response payload.
// Requests are taken one at a time; the store read is registered
// and the controller holds off the next beat until the result is loaded.
// A stalled response holds its payload; while it is stalled and full, the
// request side is stalled too.
// Reset empties the deque, sets capacity to 128, clears rsp_valid and idles the controller.
module circular_deque (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_func,
   input  logic signed [cdq_pkg::DATA_WIDTH-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [cdq_pkg::DATA_WIDTH-1:0] rsp_removed_value,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_is_full,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cdq_pkg::CAP_W-1:0]            csr_capacity
);
   import cdq_pkg::*;

   cmd_type cmd;

   // Sequencing and handshakes
   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   // Pointers, store and response payload
   cdq_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_func          (req_func),
      .req_value         (req_value),
      .csr_capacity      (csr_capacity),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full)
   );

endmodule

// ----- design/cdq_checker.sv -----
`include "circular_deque_assert.svh"

module cdq_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [cdq_pkg::DATA_WIDTH-1:0] rsp_removed_value,
   input logic [1:0]                           rsp_status,
   input logic                                 rsp_is_empty,
   input logic                                 rsp_is_full
);
   import cdq_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // A request beat yields rsp_valid once the controller's load state has passed
   `CDQ_ASSERT_NXT(a_rsp_follows, clock, reset, req_beat, ##1 rsp_valid)

   // One request at a time
   `CDQ_ASSERT_NXT(a_one_inflight, clock, reset, req_beat, req_stall)

   // Underflow returns zero on an empty deque
   `CDQ_ASSERT_IMP(a_underflow, clock, reset, rsp_valid && (rsp_status == STATUS_UNDERFLOW), (rsp_removed_value == '0) && rsp_is_empty)

   // Overflow only on a full, non-empty deque
   `CDQ_ASSERT_IMP(a_overflow, clock, reset, rsp_valid && (rsp_status == STATUS_OVERFLOW), rsp_is_full && !rsp_is_empty)

   // A stalled response holds
   `CDQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_removed_value) && $stable(rsp_status))

endmodule

bind circular_deque cdq_checker u_cdq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_removed_value (rsp_removed_value),
   .rsp_status        (rsp_status),
   .rsp_is_empty      (rsp_is_empty),
   .rsp_is_full       (rsp_is_full)
);
